### src/fac_pkg.sv
// Shared types and constants for the frustum box culler.
package fac_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_COLS   = 4;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_AXES   = 3;
  localparam int COORD_W    = 32;
  localparam int COEF_W     = COORD_W + 1;
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int D_SHIFT    = 16;
  localparam int DTERM_W    = COEF_W + D_SHIFT;
  localparam int SUM_W      = PROD_W + 2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_BOX  = 1'b1;

  localparam logic [2:0] PL_LEFT   = 3'd0;
  localparam logic [2:0] PL_RIGHT  = 3'd1;
  localparam logic [2:0] PL_BOTTOM = 3'd2;
  localparam logic [2:0] PL_TOP    = 3'd3;
  localparam logic [2:0] PL_NEAR   = 3'd4;
  localparam logic [2:0] PL_FAR    = 3'd5;

  typedef logic [NUM_COLS-1:0][COORD_W-1:0] row_t;
  typedef row_t [NUM_ROWS-1:0] matrix_t;
  typedef logic [NUM_AXES-1:0][COORD_W-1:0] vec3_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COEF_W-1:0] n;
    logic [COEF_W-1:0]               d;
  } plane_t;

  typedef plane_t [NUM_PLANES-1:0] plane_set_t;

endpackage

### src/fac_planes.sv
// Matrix rows and the six frustum planes formed from them.
module fac_planes
  import fac_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load_en,
  input  logic [$clog2(NUM_ROWS)-1:0]  row_index,
  input  row_t                         row_data,
  output plane_set_t                   planes
);

  matrix_t    mat_r;
  matrix_t    mat_nxt;
  plane_set_t planes_r;
  plane_set_t planes_nxt;

  logic [NUM_COLS-1:0][COEF_W-1:0] w_ext;
  logic [NUM_COLS-1:0][COEF_W-1:0] x_ext;
  logic [NUM_COLS-1:0][COEF_W-1:0] y_ext;
  logic [NUM_COLS-1:0][COEF_W-1:0] z_ext;
  logic [NUM_PLANES-1:0][NUM_COLS-1:0][COEF_W-1:0] coef;

  always_comb begin
    mat_nxt = mat_r;
    mat_nxt[row_index] = row_data;
  end

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      w_ext[c] = {mat_nxt[3][c][COORD_W-1], mat_nxt[3][c]};
      x_ext[c] = {mat_nxt[0][c][COORD_W-1], mat_nxt[0][c]};
      y_ext[c] = {mat_nxt[1][c][COORD_W-1], mat_nxt[1][c]};
      z_ext[c] = {mat_nxt[2][c][COORD_W-1], mat_nxt[2][c]};
      coef[PL_LEFT][c]   = w_ext[c] + x_ext[c];
      coef[PL_RIGHT][c]  = w_ext[c] - x_ext[c];
      coef[PL_BOTTOM][c] = w_ext[c] + y_ext[c];
      coef[PL_TOP][c]    = w_ext[c] - y_ext[c];
      coef[PL_NEAR][c]   = z_ext[c];
      coef[PL_FAR][c]    = w_ext[c] - z_ext[c];
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        planes_nxt[p].n[j] = coef[p][j];
      end
      planes_nxt[p].d = coef[p][NUM_COLS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r    <= '0;
      planes_r <= '0;
    end else if (load_en) begin
      mat_r    <= mat_nxt;
      planes_r <= planes_nxt;
    end
  end

  assign planes = planes_r;

  a_near_tracks_row2: assert property (@(posedge clk) disable iff (!rst_n)
    planes_r[PL_NEAR].d == {mat_r[2][3][COORD_W-1], mat_r[2][3]})
    else $error("near plane offset differs from stored row 2");

  a_far_tracks_rows: assert property (@(posedge clk) disable iff (!rst_n)
    planes_r[PL_FAR].n[0] == ({mat_r[3][0][COORD_W-1], mat_r[3][0]}
                            - {mat_r[2][0][COORD_W-1], mat_r[2][0]}))
    else $error("far plane normal differs from stored rows");

  a_load_writes_row: assert property (@(posedge clk) disable iff (!rst_n)
    load_en |=> mat_r[$past(row_index)] == $past(row_data))
    else $error("row load not captured");

endmodule

### src/fac_test.sv
// Pipelined plane test of one box per cycle against the six planes, while the output is not stalled.
module fac_test
  import fac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       box_en,
  input  vec3_t      box_min,
  input  vec3_t      box_max,
  input  plane_set_t planes,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_intersects
);

  logic adv;

  logic  v0_r;
  vec3_t mn0_r;
  vec3_t mx0_r;

  logic                      v1_r;
  logic signed [PROD_W-1:0]  prod_nxt [NUM_PLANES][NUM_AXES];
  logic signed [PROD_W-1:0]  prod1_r  [NUM_PLANES][NUM_AXES];
  logic signed [DTERM_W-1:0] dsh_nxt  [NUM_PLANES];
  logic signed [DTERM_W-1:0] dsh1_r   [NUM_PLANES];
  logic [NUM_PLANES-1:0]     zero_nxt;
  logic [NUM_PLANES-1:0]     zero1_r;

  logic                    v2_r;
  logic signed [SUM_W-1:0] pa_nxt [NUM_PLANES];
  logic signed [SUM_W-1:0] pb_nxt [NUM_PLANES];
  logic signed [SUM_W-1:0] pa2_r  [NUM_PLANES];
  logic signed [SUM_W-1:0] pb2_r  [NUM_PLANES];
  logic [NUM_PLANES-1:0]   zero2_r;

  logic signed [SUM_W-1:0] tot [NUM_PLANES];
  logic [NUM_PLANES-1:0]   pass;
  logic                    out_valid_r;
  logic                    hit_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  for (genvar gp = 0; gp < NUM_PLANES; gp++) begin : g_plane
    for (genvar gj = 0; gj < NUM_AXES; gj++) begin : g_axis
      logic signed [COEF_W-1:0]  nco;
      logic signed [COORD_W-1:0] sel;
      // a positive normal component picks the max corner, a negative one the min
      assign nco = planes[gp].n[gj];
      assign sel = nco[COEF_W-1] ? mn0_r[gj] : mx0_r[gj];
      assign prod_nxt[gp][gj] = nco * sel;
    end
    assign dsh_nxt[gp]  = {planes[gp].d, {D_SHIFT{1'b0}}};
    assign zero_nxt[gp] = (planes[gp].n == '0);
    assign pa_nxt[gp]   = SUM_W'(prod1_r[gp][0]) + SUM_W'(prod1_r[gp][1]);
    assign pb_nxt[gp]   = SUM_W'(prod1_r[gp][2]) + SUM_W'(dsh1_r[gp]);
    assign tot[gp]      = pa2_r[gp] + pb2_r[gp];
    assign pass[gp]     = zero2_r[gp] || !tot[gp][SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= box_en;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mn0_r   <= box_min;
      mx0_r   <= box_max;
      prod1_r <= prod_nxt;
      dsh1_r  <= dsh_nxt;
      zero1_r <= zero_nxt;
      pa2_r   <= pa_nxt;
      pb2_r   <= pb_nxt;
      zero2_r <= zero1_r;
      hit_r   <= &pass;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_intersects = hit_r;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v0_r, v1_r, v2_r, out_valid_r}))
    else $error("pipeline moved while output stalled");

  a_zero_planes_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v2_r && (&zero2_r)) |=> (out_valid_r && hit_r))
    else $error("box culled with all planes degenerate");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !v2_r) |=> !out_valid_r)
    else $error("result without a box transaction");

endmodule

### src/frustum_aabb_cull.sv
// Top level of the view-frustum box culler.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   kind, row_index, row_c0..3, box min/max
//   out_     output     out_valid / out_stall intersects
//
// One transaction per cycle while in_stall is low.
// Row loads take effect for the next box transaction and produce no result.
// A box result passes the input register, the multiply stage, the pairwise add stage and the final add.
// A stalled result freezes the whole pipeline and raises in_stall.
// Reset clears the stored matrix to zero, so every plane passes until rows load.
module frustum_aabb_cull
  import fac_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [1:0]                 in_row_index,
  input  logic signed [COORD_W-1:0]  in_row_c0,
  input  logic signed [COORD_W-1:0]  in_row_c1,
  input  logic signed [COORD_W-1:0]  in_row_c2,
  input  logic signed [COORD_W-1:0]  in_row_c3,
  input  logic signed [COORD_W-1:0]  in_box_min_x,
  input  logic signed [COORD_W-1:0]  in_box_min_y,
  input  logic signed [COORD_W-1:0]  in_box_min_z,
  input  logic signed [COORD_W-1:0]  in_box_max_x,
  input  logic signed [COORD_W-1:0]  in_box_max_y,
  input  logic signed [COORD_W-1:0]  in_box_max_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_intersects
);

  logic       load_en;
  logic       box_en;
  row_t       row_data;
  vec3_t      box_min;
  vec3_t      box_max;
  plane_set_t planes;

  assign load_en  = in_valid && !in_stall && (in_kind == KIND_LOAD);
  assign box_en   = in_valid && (in_kind == KIND_BOX);
  assign row_data = {in_row_c3, in_row_c2, in_row_c1, in_row_c0};
  assign box_min  = {in_box_min_z, in_box_min_y, in_box_min_x};
  assign box_max  = {in_box_max_z, in_box_max_y, in_box_max_x};

  fac_planes u_planes (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (load_en),
    .row_index (in_row_index),
    .row_data  (row_data),
    .planes    (planes)
  );

  fac_test u_test (
    .clk            (clk),
    .rst_n          (rst_n),
    .box_en         (box_en),
    .box_min        (box_min),
    .box_max        (box_max),
    .planes         (planes),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_intersects (out_intersects)
  );

endmodule

### tb/sv/frustum_aabb_cull_test.sv
// Self-checking testbench for the frustum box culler: row loads, box tests, result check.
`timescale 1ns / 1ps

module frustum_aabb_cull_test;
  import fac_pkg::*;

  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {PREDICT, CULLED, VISIBLE} row_verdict_t;

  typedef struct packed {
    logic                              kind;
    logic [1:0]                        row_index;
    logic [NUM_COLS-1:0][COORD_W-1:0]  row;
    logic [NUM_AXES-1:0][COORD_W-1:0]  lo;
    logic [NUM_AXES-1:0][COORD_W-1:0]  hi;
    row_verdict_t                      verdict;
  } cull_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_kind;
  logic [1:0] in_row_index;
  logic signed [COORD_W-1:0] in_row_c0, in_row_c1, in_row_c2, in_row_c3;
  logic signed [COORD_W-1:0] in_box_min_x, in_box_min_y, in_box_min_z;
  logic signed [COORD_W-1:0] in_box_max_x, in_box_max_y, in_box_max_z;
  logic out_valid;
  logic out_stall;
  logic out_intersects;

  cull_item_t pending_transactions [$];
  cull_item_t directed_rows [$];
  logic       expected_hits [$];
  cull_item_t on_wire;
  logic       hit_wanted;
  logic signed [COORD_W-1:0] view_proj [NUM_ROWS][NUM_COLS];
  int mismatches = 0;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles = 0;

  frustum_aabb_cull uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_row_index(in_row_index),
    .in_row_c0(in_row_c0), .in_row_c1(in_row_c1),
    .in_row_c2(in_row_c2), .in_row_c3(in_row_c3),
    .in_box_min_x(in_box_min_x), .in_box_min_y(in_box_min_y),
    .in_box_min_z(in_box_min_z), .in_box_max_x(in_box_max_x),
    .in_box_max_y(in_box_max_y), .in_box_max_z(in_box_max_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_intersects(out_intersects)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic cull_item_t load_row(logic [1:0] idx, logic [31:0] c0, logic [31:0] c1,
                                          logic [31:0] c2, logic [31:0] c3);
    cull_item_t t;
    t.kind      = KIND_LOAD;
    t.row_index = idx;
    t.row       = {c3, c2, c1, c0};
    t.lo        = {$urandom, $urandom, $urandom};
    t.hi        = {$urandom, $urandom, $urandom};
    t.verdict   = PREDICT;
    return t;
  endfunction

  function automatic cull_item_t box_row(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                                         logic [31:0] x1, logic [31:0] y1, logic [31:0] z1,
                                         row_verdict_t verdict);
    cull_item_t t;
    t.kind      = KIND_BOX;
    t.row_index = 2'($urandom);
    t.row       = {$urandom, $urandom, $urandom, $urandom};
    t.lo        = {z0, y0, x0};
    t.hi        = {z1, y1, x1};
    t.verdict   = verdict;
    return t;
  endfunction

  function automatic longint plane_coef(int p, int col);
    longint w;
    w = longint'(view_proj[3][col]);
    case (3'(p))
      PL_LEFT:   return w + longint'(view_proj[0][col]);
      PL_RIGHT:  return w - longint'(view_proj[0][col]);
      PL_BOTTOM: return w + longint'(view_proj[1][col]);
      PL_TOP:    return w - longint'(view_proj[1][col]);
      PL_NEAR:   return longint'(view_proj[2][col]);
      default:   return w - longint'(view_proj[2][col]);
    endcase
  endfunction

  function automatic logic box_touches(cull_item_t t);
    longint pair_sum [NUM_AXES];
    longint span [NUM_AXES];
    longint coef [NUM_COLS];
    longint mag;
    logic signed [127:0] acc;
    logic hit;
    hit = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      pair_sum[a] = longint'($signed(t.lo[a])) + longint'($signed(t.hi[a]));
      span[a]     = longint'($signed(t.hi[a])) - longint'($signed(t.lo[a]));
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int c = 0; c < NUM_COLS; c++) coef[c] = plane_coef(p, c);
      if (hit && (coef[0] != 0 || coef[1] != 0 || coef[2] != 0)) begin
        acc = coef[3] * 64'sd131072;
        for (int a = 0; a < NUM_AXES; a++) begin
          mag = (coef[a] < 0) ? -coef[a] : coef[a];
          acc = acc + coef[a] * pair_sum[a];
          acc = acc + mag * span[a];
        end
        if (acc < 0) hit = 1'b0;
      end
    end
    return hit;
  endfunction

  task automatic absorb_transaction(cull_item_t t);
    if (t.kind == KIND_LOAD) begin
      for (int c = 0; c < NUM_COLS; c++) view_proj[t.row_index][c] = $signed(t.row[c]);
    end else begin
      case (t.verdict)
        CULLED:  expected_hits.push_back(1'b0);
        VISIBLE: expected_hits.push_back(1'b1);
        default: expected_hits.push_back(box_touches(t));
      endcase
    end
  endtask

  function automatic logic [31:0] rand_elem(int mode);
    case ($urandom_range(3))
      0: return (mode == 9) ? Q_MIN : 32'h0;
      1: return (mode == 9) ? Q_MAX : Q_ONE;
      default: ;
    endcase
    if (mode <= 5) return 32'($urandom_range(32'h80000)) - 32'h40000;
    if (mode == 6) return $urandom;
    return (mode == 9) ? Q_NEG_ONE : (($urandom_range(1) == 0) ? Q_NEG_ONE : Q_ONE);
  endfunction

  task automatic queue_matrix();
    int mode;
    mode = $urandom_range(9);
    for (int r = 0; r < NUM_ROWS; r++)
      pending_transactions.push_back(load_row(2'(r), rand_elem(mode), rand_elem(mode),
                                              rand_elem(mode), rand_elem(mode)));
  endtask

  function automatic cull_item_t random_box();
    logic [NUM_AXES-1:0][31:0] lo3;
    logic [NUM_AXES-1:0][31:0] hi3;
    logic [31:0] centre;
    logic [31:0] half;
    int style;
    style = $urandom_range(19);
    for (int a = 0; a < NUM_AXES; a++) begin
      centre = 32'($urandom_range(32'h60000)) - 32'h30000;
      half   = 32'($urandom_range(32'h18000));
      if (style == 0) begin
        lo3[a] = $urandom;
        hi3[a] = $urandom;
      end else if (style == 1) begin
        lo3[a] = ($urandom_range(1) == 0) ? Q_MIN : Q_MAX;
        hi3[a] = ($urandom_range(1) == 0) ? Q_MIN : Q_MAX;
      end else if (style == 2 && $urandom_range(1) == 0) begin
        lo3[a] = centre + half;
        hi3[a] = centre - half;
      end else begin
        lo3[a] = centre - half;
        hi3[a] = centre + half;
      end
    end
    return box_row(lo3[0], lo3[1], lo3[2], hi3[0], hi3[1], hi3[2], PREDICT);
  endfunction

  task automatic queue_random(int count);
    int made;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_matrix();
        made += NUM_ROWS;
      end else if (pick < 12) begin
        pending_transactions.push_back(load_row(2'($urandom), $urandom, $urandom,
                                                $urandom, $urandom));
        made++;
      end else begin
        pending_transactions.push_back(random_box());
        made++;
      end
    end
  endtask

  task automatic drain_sender();
    while (pending_transactions.size() != 0 || in_valid) @(negedge clk);
  endtask

  task automatic await_results();
    while (expected_hits.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("box result with no box transaction pending");
        end else begin
          hit_wanted = expected_hits.pop_front();
          if (out_intersects !== hit_wanted)
            report_mismatch($sformatf("intersects got %b, want %b", out_intersects,
                                      hit_wanted));
        end
      end
      if (in_valid && !in_stall) absorb_transaction(on_wire);
      if (!(in_valid && in_stall)) begin
        if (pending_transactions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = pending_transactions.pop_front();
          in_valid     <= 1'b1;
          in_kind      <= on_wire.kind;
          in_row_index <= on_wire.row_index;
          in_row_c0    <= on_wire.row[0];
          in_row_c1    <= on_wire.row[1];
          in_row_c2    <= on_wire.row[2];
          in_row_c3    <= on_wire.row[3];
          in_box_min_x <= on_wire.lo[0];
          in_box_min_y <= on_wire.lo[1];
          in_box_min_z <= on_wire.lo[2];
          in_box_max_x <= on_wire.hi[0];
          in_box_max_y <= on_wire.hi[1];
          in_box_max_z <= on_wire.hi[2];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_LOAD;
    in_row_index = 2'd0;
    {in_row_c0, in_row_c1, in_row_c2, in_row_c3} = '0;
    {in_box_min_x, in_box_min_y, in_box_min_z} = '0;
    {in_box_max_x, in_box_max_y, in_box_max_z} = '0;
    out_stall = 1'b0;
    send_idle_pct = 18;
    recv_stall_pct = 66;
    for (int r = 0; r < NUM_ROWS; r++)
      for (int c = 0; c < NUM_COLS; c++) view_proj[r][c] = '0;

    directed_rows.push_back(box_row(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, VISIBLE));
    directed_rows.push_back(box_row(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, VISIBLE));
    directed_rows.push_back(load_row(2'd0, Q_ONE, 32'h0, 32'h0, 32'h0));
    directed_rows.push_back(load_row(2'd1, 32'h0, Q_ONE, 32'h0, 32'h0));
    directed_rows.push_back(load_row(2'd2, 32'h0, 32'h0, Q_ONE, 32'h0));
    directed_rows.push_back(load_row(2'd3, 32'h0, 32'h0, 32'h0, Q_ONE));
    directed_rows.push_back(box_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, VISIBLE));
    directed_rows.push_back(box_row(32'h5_0000, 32'h0, 32'h0, 32'h6_0000, 32'h0, 32'h0,
                                    CULLED));
    directed_rows.push_back(box_row(Q_ONE, 32'h0, 32'h0, 32'h2_0000, 32'h0, 32'h0, VISIBLE));
    directed_rows.push_back(box_row(32'h1_0001, 32'h0, 32'h0, 32'h2_0000, 32'h0, 32'h0,
                                    CULLED));
    directed_rows.push_back(box_row(32'h1_1999, 32'h0, 32'h0, 32'h0_B333, 32'h0, 32'h0,
                                    CULLED));
    directed_rows.push_back(box_row(32'h0, 32'h0, Q_NEG_ONE, 32'h0, 32'h0, 32'hFFFF_8000,
                                    CULLED));
    directed_rows.push_back(box_row(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, VISIBLE));
    directed_rows.push_back(load_row(2'd0, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_rows.push_back(load_row(2'd1, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_rows.push_back(load_row(2'd2, 32'h0, 32'h0, 32'h0, 32'h0));
    directed_rows.push_back(load_row(2'd3, 32'h0, 32'h0, 32'h0, Q_NEG_ONE));
    directed_rows.push_back(box_row(Q_MAX, Q_MIN, 32'h0, Q_MAX, Q_MIN, 32'h0, VISIBLE));
    directed_rows.push_back(load_row(2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    directed_rows.push_back(load_row(2'd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    directed_rows.push_back(load_row(2'd2, Q_MIN, Q_MAX, 32'h0, Q_ONE));
    directed_rows.push_back(load_row(2'd3, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    directed_rows.push_back(box_row(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, PREDICT));
    directed_rows.push_back(box_row(Q_MAX, 32'h0, Q_MIN, Q_MAX, 32'h0, Q_MIN, PREDICT));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) pending_transactions.push_back(directed_rows[i]);
    queue_random(180);
    drain_sender();
    await_results();

    send_idle_pct = 66;
    recv_stall_pct = 18;
    queue_random(180);
    drain_sender();
    await_results();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(180);
    drain_sender();
    await_results();
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
